// File: design/nprd_pkg.sv
// Package for the nibble-pair RSA decrypt core: word widths, nibble constants
// and the command/status structs shared by the core and its submodules.
// No dependencies.
`default_nettype none
package nprd_pkg;

    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int CNT_W    = $clog2(WORD_W);

    localparam logic [BYTE_W-1:0] NIBBLE_MASK  = 8'h0f;
    localparam int                NIBBLE_SHIFT = 4;

    localparam logic [WORD_W-1:0] MODULUS_RST  = 16'd143;
    localparam logic [WORD_W-1:0] EXPONENT_RST = 16'd103;

    // configuration register indexes
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    // start of one serial modular multiply: result = a * b mod n
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mm_cmd;

    // start of one exponentiation
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] cipher;
    } t_exp_cmd;

    // end of one exponentiation
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] result;
    } t_exp_sts;

endpackage
`default_nettype wire

// File: design/nprd_modmul.sv
// Bit-serial interleaved modular multiplier: one bit of b per cycle, MSB first.
// Uses nprd_pkg for widths and the command struct. A modulus of zero wraps at 2^16.
`default_nettype none
module nprd_modmul import nprd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mm_cmd           i_cmd,
    input  wire logic [WORD_W-1:0] i_modulus,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_result
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic              wrap;
    logic [WORD_W:0]   mod_x;
    logic [WORD_W:0]   dbl, dbl_red, sum, sum_red;

    // one step: acc = 2*acc mod n, then add a mod n when the b bit is set
    always_comb begin
        wrap  = (i_modulus == '0);
        mod_x = {1'b0, i_modulus};
        dbl   = {r_acc, 1'b0};
        if (!wrap && dbl >= mod_x) begin
            dbl_red = dbl - mod_x;
        end else begin
            dbl_red = dbl;
        end
        sum = {1'b0, dbl_red[WORD_W-1:0]} + {1'b0, r_a};
        if (!wrap && sum >= mod_x) begin
            sum_red = sum - mod_x;
        end else begin
            sum_red = sum;
        end
        if (r_b[WORD_W-1]) begin
            n_acc = sum_red[WORD_W-1:0];
        end else begin
            n_acc = dbl_red[WORD_W-1:0];
        end
    end

    // control: load on start, count sixteen steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // datapath: shift b out, accumulate
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WORD_W-2:0], 1'b0};
        end else if (i_cmd.start) begin
            r_acc <= '0;
            r_a   <= i_cmd.a;
            r_b   <= i_cmd.b;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

// File: design/nprd_expo.sv
// Right-to-left square-and-multiply sequencer over two serial multipliers.
// Uses nprd_pkg and instantiates nprd_modmul twice (square and multiply in parallel).
`default_nettype none
module nprd_expo import nprd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_exp_cmd          i_cmd,
    input  wire logic [WORD_W-1:0] i_modulus,
    input  wire logic [WORD_W-1:0] i_exponent,
    output t_exp_sts               o_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED  = 2'd1;
    localparam logic [1:0] ST_LOOP = 2'd2;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_W - 1);

    logic [1:0]        r_state;
    logic              r_go;
    logic              r_done;
    logic [CNT_W-1:0]  r_k;
    logic [WORD_W-1:0] r_e;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [BYTE_W-1:0] r_base;

    logic [WORD_W-1:0] one_mod;
    t_mm_cmd           sq_cmd, mu_cmd;
    logic              sq_done, mu_done;
    logic [WORD_W-1:0] sq_res, mu_res;

    // 1 mod n: zero only for n of one
    assign one_mod = (i_modulus == WORD_W'(1)) ? '0 : WORD_W'(1);

    // operand select: base reduction first, then x*x and y*x
    always_comb begin
        sq_cmd.start = r_go;
        if (r_state == ST_RED) begin
            sq_cmd.a = one_mod;
            sq_cmd.b = {{(WORD_W-BYTE_W){1'b0}}, r_base};
        end else begin
            sq_cmd.a = r_x;
            sq_cmd.b = r_x;
        end
        mu_cmd.start = r_go && (r_state == ST_LOOP);
        mu_cmd.a     = r_y;
        mu_cmd.b     = r_x;
    end

    nprd_modmul u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (sq_cmd),
        .i_modulus (i_modulus),
        .o_done    (sq_done),
        .o_result  (sq_res)
    );

    nprd_modmul u_mu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mu_cmd),
        .i_modulus (i_modulus),
        .o_done    (mu_done),
        .o_result  (mu_res)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_go   <= 1'b0;
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_state <= ST_RED;
                        r_go    <= 1'b1;
                    end
                end
                ST_RED: begin
                    if (sq_done) begin
                        r_state <= ST_LOOP;
                        r_go    <= 1'b1;
                        r_k     <= '0;
                    end
                end
                ST_LOOP: begin
                    if (sq_done) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == LAST_BIT) begin
                            r_state <= ST_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_go <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // operands: latch base and exponent, update x and y per bit
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd.start) begin
            r_base <= i_cmd.cipher;
            r_e    <= i_exponent;
        end
        if (r_state == ST_RED && sq_done) begin
            r_x <= sq_res;
            r_y <= one_mod;
        end
        if (r_state == ST_LOOP && sq_done) begin
            r_x <= sq_res;
            r_e <= {1'b0, r_e[WORD_W-1:1]};
            if (r_e[0] && mu_done) begin
                r_y <= mu_res;
            end
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.result = r_y[BYTE_W-1:0];

endmodule
`default_nettype wire

// File: design/nibble_pair_rsa_decrypt_core.sv
// A first character without line end gives no result.
// A decrypted byte takes 17 serial modular multiply passes in the bit-serial
// multipliers, one exponent bit per multiply pass.
// One item at a time; after a byte is accepted the next item waits until its
// result is dropped or moves to the output register; other items go one per cycle
// unless the output is stalled. Sync active-low reset.
`default_nettype none
module nibble_pair_rsa_decrypt_core import nprd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_char_in,
    input  wire logic              i_line_end,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [BYTE_W-1:0]      o_plain_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data
);

    logic [WORD_W-1:0] r_modulus;
    logic [WORD_W-1:0] r_exponent;
    logic [NIB_W-1:0]  r_high_nib;
    logic              r_second;
    logic              r_stopped;
    logic              r_comp;
    logic              r_job_end;
    logic              r_pend_valid;
    logic [BYTE_W-1:0] r_pend_byte;
    logic              r_pend_bv;
    logic              r_pend_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bv;
    logic              r_out_last;

    logic              busy, out_free, acc;
    logic [NIB_W-1:0]  nib;
    logic [BYTE_W-1:0] cipher;
    logic              have_byte, comp_start, stop_now, imm_valid, plain_nz;
    t_exp_cmd          exp_cmd;
    t_exp_sts          exp_sts;

    // handshake
    assign busy       = r_comp || r_pend_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy || !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // assemble the ciphertext byte from nibble pairs
    always_comb begin
        nib = i_char_in[NIB_W-1:0] & NIBBLE_MASK[NIB_W-1:0];
        if (r_second) begin
            cipher = BYTE_W'({r_high_nib, nib});
        end else begin
            cipher = BYTE_W'({nib, {NIBBLE_SHIFT{1'b0}}});
        end
        have_byte  = r_second || i_line_end;
        comp_start = acc && have_byte && !r_stopped && (cipher != '0);
        stop_now   = acc && have_byte && !r_stopped && (cipher == '0);
        imm_valid  = acc && i_line_end && !comp_start;
        plain_nz   = (exp_sts.result != '0);
    end

    assign exp_cmd.start  = comp_start;
    assign exp_cmd.cipher = cipher;

    nprd_expo u_expo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (exp_cmd),
        .i_modulus  (r_modulus),
        .i_exponent (r_exponent),
        .o_sts      (exp_sts)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RST;
            r_exponent <= EXPONENT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                default:      r_modulus  <= r_modulus;
            endcase
        end
    end

    // line framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_nib <= '0;
            r_second   <= 1'b0;
            r_stopped  <= 1'b0;
            r_comp     <= 1'b0;
            r_job_end  <= 1'b0;
        end else begin
            if (acc) begin
                if (i_line_end) begin
                    r_high_nib <= '0;
                    r_second   <= 1'b0;
                    r_stopped  <= 1'b0;
                end else begin
                    if (!r_second) begin
                        r_high_nib <= nib;
                    end
                    r_second <= !r_second;
                    if (stop_now) begin
                        r_stopped <= 1'b1;
                    end
                end
            end
            if (comp_start) begin
                r_comp    <= 1'b1;
                r_job_end <= i_line_end;
            end
            // a zero plaintext stops the rest of the line
            if (exp_sts.done) begin
                r_comp <= 1'b0;
                if (!plain_nz && !r_job_end) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

    // hold a finished exponentiation until the output register frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (exp_sts.done) begin
            r_pend_valid <= plain_nz || r_job_end;
        end else if (r_pend_valid && out_free) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exp_sts.done) begin
            r_pend_byte <= exp_sts.result;
            r_pend_bv   <= plain_nz;
            r_pend_last <= r_job_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= imm_valid || r_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (imm_valid) begin
                r_out_byte <= '0;
                r_out_bv   <= 1'b0;
                r_out_last <= 1'b1;
            end else if (r_pend_valid) begin
                r_out_byte <= r_pend_byte;
                r_out_bv   <= r_pend_bv;
                r_out_last <= r_pend_last;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_last       = r_out_last;

endmodule
`default_nettype wire

// File: design/nprd_checker.sv
// Port-level checks for the nibble-pair RSA decrypt core, bound to the top level.
// Uses nprd_pkg for widths; attaches by the bind statement below.
`default_nettype none
module nprd_checker import nprd_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [BYTE_W-1:0] o_plain_byte,
    input wire logic              o_byte_valid,
    input wire logic              o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // hold off input while a stalled result waits
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input open while result stalled");

    // a result without a byte carries zero and must end the line
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> (o_plain_byte == '0) && o_last)
        else $error("empty result not a clean line end");

    // a delivered byte is never zero
    a_byte_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> (o_plain_byte != '0))
        else $error("zero byte marked valid");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind nibble_pair_rsa_decrypt_core nprd_checker u_nprd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_plain_byte (o_plain_byte),
    .o_byte_valid (o_byte_valid),
    .o_last       (o_last)
);
`default_nettype wire
